FILE: rtl/fplw_pkg.sv
`timescale 1ns / 1ps
package fplw_pkg;

   // Physical address width; address bits at or above it are dropped
   localparam int PHYS_ADDR_BITS = 52;
   localparam int ADDR_W         = 52;
   localparam int LIN_W          = 48;
   localparam int ENTRY_W        = 64;
   localparam int REQ_DATA_W     = 168;
   localparam int RSP_DATA_W     = 112;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [ADDR_W-1:0] PA_MASK  = {ADDR_W{1'b1}} >> (ADDR_W - PHYS_ADDR_BITS);
   localparam logic [ADDR_W-1:0] BASE_MASK     = 52'hF_FFFF_FFFF_F000 & PA_MASK;
   localparam logic [ADDR_W-1:0] FRAME_1G_MASK = 52'hF_FFFF_C000_0000 & PA_MASK;
   localparam logic [ADDR_W-1:0] FRAME_2M_MASK = 52'hF_FFFF_FFE0_0000 & PA_MASK;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_LARGE   = 7;

   typedef enum logic {
      OP_START = 1'b0,
      OP_REPLY = 1'b1
   } op_type;

   typedef enum logic {
      KIND_READ = 1'b0,
      KIND_DONE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_PML4E_NP = 3'd1,
      ST_PDPTE_NP = 3'd2,
      ST_PDE_NP  = 3'd3,
      ST_PTE_NP  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PG_4K = 2'd0,
      PG_2M = 2'd1,
      PG_1G = 2'd2
   } size_type;

   typedef enum logic [1:0] {
      LVL_PML4 = 2'd0,
      LVL_PDPT = 2'd1,
      LVL_PD   = 2'd2,
      LVL_PT   = 2'd3
   } level_type;

   // Classified item between front and back
   typedef struct packed {
      op_type             op;
      logic [ADDR_W-1:0]  word;      // masked table base on start, entry bits on reply
      logic [LIN_W-1:0]   linear;
      logic               present;
      logic               big_page;
   } item_type;

   // Entry address: table base OR (9-bit index for the level) times 8
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [LIN_W-1:0]  lin,
                                                    input level_type         lvl);
      logic [8:0] idx;
      case (lvl)
         LVL_PML4: idx = lin[47:39];
         LVL_PDPT: idx = lin[38:30];
         LVL_PD:   idx = lin[29:21];
         LVL_PT:   idx = lin[20:12];
         default:  idx = lin[20:12];
      endcase
      entry_addr = (base & BASE_MASK) | {{(ADDR_W-12){1'b0}}, idx, 3'b000};
   endfunction

endpackage

FILE: rtl/four_level_page_walker.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Item
// req_      in   req_tvalid/tready      tuser operation; tdata root, linear, entry
// rsp_      out  rsp_tvalid/tready      tuser result_kind; tdata read addr, status,
//                                        phys addr, page size
// An item is taken every cycle while the two-entry queue has room; the back end
// takes the queued item at the head when the result register is free and
// carries out one walk step for it, loading its result into the result register.
// The result register frees when taken, so the back end keeps going while
// rsp_tready is high. Out-of-order items are dropped without a result. Reset
// (synchronous) empties the queue and idles the walk.
module four_level_page_walker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [51:0] root_register, [99:52] linear_address, [163:100] table_entry
   input  logic [fplw_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] operation
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [51:0] read_address, [54:52] status, [106:55] physical_address,
   // [108:107] page_size
   output logic [fplw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] result_kind
   output logic                             rsp_tuser
);
   import fplw_pkg::*;

   logic      q_valid, q_ready;
   item_type  q_item;

   fplw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   fplw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/fplw_front.sv
`timescale 1ns / 1ps
module fplw_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fplw_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   output logic                             q_valid,
   input  logic                             q_ready,
   output fplw_pkg::item_type               q_item
);
   import fplw_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   item_type           cls_item;
   logic               push, pop;

   // Classify: start carries the root base, reply carries the entry
   always_comb begin
      cls_item.op       = op_type'(req_tuser);
      cls_item.linear   = req_tdata[99:52];
      cls_item.present  = req_tdata[100 + BIT_PRESENT];
      cls_item.big_page = req_tdata[100 + BIT_LARGE];
      if (cls_item.op == OP_START) begin
         cls_item.word = req_tdata[51:0] & BASE_MASK;
      end else begin
         cls_item.word = req_tdata[151:100];
      end
   end

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_valid && q_ready;
   assign q_item     = mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls_item;
      end
   end

endmodule

FILE: rtl/fplw_back.sv
`timescale 1ns / 1ps
module fplw_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   output logic                             q_ready,
   input  fplw_pkg::item_type               q_item,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fplw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser
);
   import fplw_pkg::*;

   logic               busy_ff, busy_in;
   level_type          level_ff, level_in;
   logic [LIN_W-1:0]   held_ff, held_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           kind_ff, kind_in;
   logic [ADDR_W-1:0]  raddr_ff, raddr_in;
   status_type         status_ff, status_in;
   logic [ADDR_W-1:0]  phys_ff, phys_in;
   size_type           size_ff, size_in;

   logic               out_free, take, emit;
   logic [ADDR_W-1:0]  frame;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_ready  = out_free;
   assign take     = q_valid && q_ready;
   assign frame    = q_item.word & PA_MASK;

   // Carry out one walk step per item
   always_comb begin
      busy_in   = busy_ff;
      level_in  = level_ff;
      held_in   = held_ff;
      emit      = 1'b0;
      kind_in   = KIND_READ;
      raddr_in  = '0;
      status_in = ST_OK;
      phys_in   = '0;
      size_in   = PG_4K;
      if (take) begin
         case (q_item.op)
            OP_START: begin
               if (!busy_ff) begin
                  emit     = 1'b1;
                  busy_in  = 1'b1;
                  level_in = LVL_PML4;
                  held_in  = q_item.linear;
                  raddr_in = entry_addr(q_item.word, q_item.linear, LVL_PML4);
               end
            end
            OP_REPLY: begin
               if (busy_ff) begin
                  emit = 1'b1;
                  if (!q_item.present) begin
                     kind_in   = KIND_DONE;
                     status_in = status_type'({1'b0, level_ff} + 3'd1);
                  end else if (level_ff == LVL_PDPT && q_item.big_page) begin
                     kind_in = KIND_DONE;
                     phys_in = (frame & FRAME_1G_MASK)
                               | {{(ADDR_W-30){1'b0}}, held_ff[29:0]};
                     size_in = PG_1G;
                  end else if (level_ff == LVL_PD && q_item.big_page) begin
                     kind_in = KIND_DONE;
                     phys_in = (frame & FRAME_2M_MASK)
                               | {{(ADDR_W-21){1'b0}}, held_ff[20:0]};
                     size_in = PG_2M;
                  end else if (level_ff == LVL_PT) begin
                     kind_in = KIND_DONE;
                     phys_in = (frame & BASE_MASK)
                               | {{(ADDR_W-12){1'b0}}, held_ff[11:0]};
                     size_in = PG_4K;
                  end else begin
                     level_in = level_type'(level_ff + 2'd1);
                     raddr_in = entry_addr(frame, held_ff, level_type'(level_ff + 2'd1));
                  end
                  if (kind_in == KIND_DONE) begin
                     busy_in  = 1'b0;
                     level_in = LVL_PML4;
                  end
               end
            end
            default: ;
         endcase
      end
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   // Walk state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         level_ff     <= LVL_PML4;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         level_ff     <= level_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff   <= kind_in;
         raddr_ff  <= raddr_in;
         status_ff <= status_in;
         phys_ff   <= phys_in;
         size_ff   <= size_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {3'b000, size_ff, phys_ff, status_ff, raddr_ff};

endmodule

FILE: tb/four_level_page_walker_tb.sv
`timescale 1ns / 1ps
module four_level_page_walker_tb;
   import fplw_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEM_TARGET    = 1450;
   localparam int DRAIN_CYCLES   = 20;

   // Page offsets kept from the linear address
   localparam logic [ADDR_W-1:0] OFFS_1G = 52'h0_0000_3FFF_FFFF;
   localparam logic [ADDR_W-1:0] OFFS_2M = 52'h0_0000_001F_FFFF;
   localparam logic [ADDR_W-1:0] OFFS_4K = 52'h0_0000_0000_0FFF;

   typedef struct packed {
      kind_type           kind;
      logic [ADDR_W-1:0]  read_addr;
      status_type         status;
      logic [ADDR_W-1:0]  phys_addr;
      size_type           size;
   } walk_result_type;

   // Walk predictor and the queue of translations still owed by the block
   class walk_predictor;
      bit                 busy;
      level_type          level;
      logic [LIN_W-1:0]   held_linear;
      walk_result_type    owed_results[$];
      int                 fault_count;
      int                 results_seen;

      function new();
         busy         = 1'b0;
         level        = LVL_PML4;
         held_linear  = '0;
         fault_count  = 0;
         results_seen = 0;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // Table base OR (index for the level) times 8
      function logic [ADDR_W-1:0] slot_addr(logic [ADDR_W-1:0] base, level_type lvl);
         logic [8:0] idx;
         idx = 9'(held_linear >> (39 - 9 * int'(lvl)));
         return (base & BASE_MASK) | (ADDR_W'(idx) << 3);
      endfunction

      // Advance the walk for one accepted item; return 1 when a result is owed
      function bit take_request(op_type op, logic [ADDR_W-1:0] root,
                                logic [LIN_W-1:0] lin, logic [ENTRY_W-1:0] entry);
         walk_result_type    r;
         logic [ADDR_W-1:0]  frame;
         r     = '0;
         frame = entry[ADDR_W-1:0];
         if (op == OP_START) begin
            if (busy) return 1'b0;
            held_linear = lin;
            busy        = 1'b1;
            level       = LVL_PML4;
            r.kind      = KIND_READ;
            r.read_addr = slot_addr(root, LVL_PML4);
         end else begin
            if (!busy) return 1'b0;
            r.kind = KIND_DONE;
            if (!entry[BIT_PRESENT]) begin
               case (level)
                  LVL_PML4: r.status = ST_PML4E_NP;
                  LVL_PDPT: r.status = ST_PDPTE_NP;
                  LVL_PD:   r.status = ST_PDE_NP;
                  default:  r.status = ST_PTE_NP;
               endcase
               busy = 1'b0;
            end else if (level == LVL_PDPT && entry[BIT_LARGE]) begin
               r.phys_addr = (frame & FRAME_1G_MASK) | ({4'b0, held_linear} & OFFS_1G);
               r.size      = PG_1G;
               busy        = 1'b0;
            end else if (level == LVL_PD && entry[BIT_LARGE]) begin
               r.phys_addr = (frame & FRAME_2M_MASK) | ({4'b0, held_linear} & OFFS_2M);
               r.size      = PG_2M;
               busy        = 1'b0;
            end else if (level == LVL_PT) begin
               r.phys_addr = (frame & BASE_MASK) | ({4'b0, held_linear} & OFFS_4K);
               r.size      = PG_4K;
               busy        = 1'b0;
            end else begin
               level       = level_type'(level + 2'd1);
               r.kind      = KIND_READ;
               r.read_addr = slot_addr(frame, level);
            end
            if (!busy) level = LVL_PML4;
         end
         owed_results.push_back(r);
         return 1'b1;
      endfunction

      task report(string field, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
         fault_count++;
      endtask

      // Compare one accepted result with the oldest owed one
      task check_response(logic kind_bit, logic [RSP_DATA_W-1:0] d);
         walk_result_type e;
         results_seen++;
         if (owed_results.size() == 0) begin
            report("unexpected result", d[63:0], '0);
            return;
         end
         e = owed_results.pop_front();
         if (kind_bit !== e.kind)
            report("result_kind", 64'(kind_bit), 64'(e.kind));
         if (d[51:0] !== e.read_addr)
            report("read_address", 64'(d[51:0]), 64'(e.read_addr));
         if (d[54:52] !== e.status)
            report("status", 64'(d[54:52]), 64'(e.status));
         if (d[106:55] !== e.phys_addr)
            report("physical_address", 64'(d[106:55]), 64'(e.phys_addr));
         if (d[108:107] !== e.size)
            report("page_size", 64'(d[108:107]), 64'(e.size));
         if (d[111:109] !== 3'b000)
            report("tdata padding", 64'(d[111:109]), '0);
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;

   walk_predictor walker_model;
   int            burst_left;
   int            items_with_result;

   four_level_page_walker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'(rand64());
   endfunction

   function automatic logic [LIN_W-1:0] rand_lin();
      return LIN_W'(rand64());
   endfunction

   // Random entry with the present and page-size bits forced
   function automatic logic [63:0] make_entry(bit present, bit big_page);
      logic [63:0] e;
      e                = rand64();
      e[BIT_PRESENT]   = present;
      e[BIT_LARGE]     = big_page;
      return e;
   endfunction

   // Offer one item in bursts with random gaps; hold until accepted
   task automatic send_item(input op_type op, input logic [ADDR_W-1:0] root,
                            input logic [LIN_W-1:0] lin, input logic [ENTRY_W-1:0] entry);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 9);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, entry, lin, root};
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (walker_model.take_request(op, root, lin, entry)) items_with_result++;
   endtask

   // Stop offering and wait for every owed result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (walker_model.pending() != 0) @(posedge clock);
   endtask

   // One well-formed walk with random content, or a stray item now and then
   task automatic random_walk();
      logic [ADDR_W-1:0]  root;
      logic [LIN_W-1:0]   lin;
      logic [ENTRY_W-1:0] entry;
      bit                 big_page;
      root  = rand_addr();
      lin   = rand_lin();
      entry = rand64();
      if ($urandom_range(0, 99) < 8) begin
         send_item(op_type'($urandom_range(0, 1)), root, lin, entry);
         return;
      end
      case ($urandom_range(0, 19))
         0: root = '0;
         1: root = '1;
         2: lin  = '0;
         3: lin  = '1;
         default: ;
      endcase
      send_item(OP_START, root, lin, entry);
      while (walker_model.busy) begin
         // drop a start into the walk at times; it must be ignored
         if ($urandom_range(0, 99) < 5) send_item(OP_START, rand_addr(), rand_lin(), rand64());
         big_page = (walker_model.level == LVL_PDPT || walker_model.level == LVL_PD)
                    ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 1) == 1);
         entry = make_entry($urandom_range(0, 99) >= 8, big_page);
         if ($urandom_range(0, 24) == 0) entry = '1;
         send_item(OP_REPLY, rand_addr(), rand_lin(), entry);
      end
   endtask

   // Receiver: check results and stall on a pattern of its own
   initial begin
      int cyc;
      int hold_left;
      bit long_done;
      cyc       = 0;
      hold_left = 0;
      long_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            walker_model.check_response(rsp_tuser, rsp_tdata);
         cyc++;
         if (!long_done && walker_model.results_seen >= 500) begin
            hold_left = 400;
            long_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case ((cyc / 200) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 4) == 0);
               default: rsp_tready <= ((cyc % 6) < 3);
            endcase
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [LIN_W-1:0] lin;
      bit               paused;
      walker_model      = new();
      burst_left        = 0;
      items_with_result = 0;
      paused            = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reply while idle, then a walk with all-ones fields and a start while busy
      send_item(OP_REPLY, '1, '1, '1);
      send_item(OP_START, '1, '1, '1);
      send_item(OP_START, '0, '0, '0);
      send_item(OP_REPLY, '0, '0, '1);
      send_item(OP_REPLY, '0, '0, '1);
      // not present at the top
      send_item(OP_START, '0, '0, '0);
      send_item(OP_REPLY, '1, '1, '0);
      // not present at PDPT, PD and PT
      lin = rand_lin();
      send_item(OP_START, rand_addr(), lin, '0);
      send_item(OP_REPLY, '0, '0, make_entry(1'b1, 1'b1));
      send_item(OP_REPLY, '0, '0, make_entry(1'b0, 1'b1));
      send_item(OP_START, rand_addr(), rand_lin(), '0);
      send_item(OP_REPLY, '0, '0, make_entry(1'b1, 1'b0));
      send_item(OP_REPLY, '0, '0, make_entry(1'b1, 1'b0));
      send_item(OP_REPLY, '0, '0, make_entry(1'b0, 1'b1));
      send_item(OP_START, rand_addr(), rand_lin(), '0);
      send_item(OP_REPLY, '0, '0, make_entry(1'b1, 1'b0));
      send_item(OP_REPLY, '0, '0, make_entry(1'b1, 1'b0));
      send_item(OP_REPLY, '0, '0, make_entry(1'b1, 1'b0));
      send_item(OP_REPLY, '0, '0, make_entry(1'b0, 1'b1));
      // 2 MB page
      send_item(OP_START, rand_addr(), '1, '0);
      send_item(OP_REPLY, '0, '0, make_entry(1'b1, 1'b0));
      send_item(OP_REPLY, '0, '0, make_entry(1'b1, 1'b0));
      send_item(OP_REPLY, '0, '0, make_entry(1'b1, 1'b1));
      drain_results();

      while (items_with_result < ITEM_TARGET) begin
         if (!paused && items_with_result >= 800) begin
            drain_results();
            paused = 1'b1;
         end
         random_walk();
      end
      req_tvalid <= 1'b0;
      while (walker_model.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (walker_model.fault_count == 0 && walker_model.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
